>>> sv/rpmcmp_pkg.sv
// ---------------------------------------------------------------------------
// rpmcmp_pkg
// Shared types and constants for the RPM command to PWM compare block.
// ---------------------------------------------------------------------------
package rpmcmp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACC_W    = 16;
    localparam int unsigned RPM_W    = 15;
    localparam int unsigned PER_W    = 16;
    localparam int unsigned SQ_W     = 2 * RPM_W;           // R*R and 18740*R
    localparam int unsigned NUM_W    = SQ_W + 8;            // 86*R*R plus headroom
    localparam int unsigned DEN_W    = 27;                  // duty denominator width
    localparam int unsigned PROD_W   = PER_W + DEN_W;       // period * remainder
    localparam int unsigned MSG_W    = 3;                   // message char index
    localparam int unsigned CFG_IDX_W = 2;

    // reciprocal of the duty denominator, scaled by 2^RECIP_SH
    localparam int unsigned RECIP_SH = 48;
    localparam int unsigned RECIP_W  = 22;
    localparam int unsigned EST_W    = DEN_W + RECIP_W;     // (x >> 16) * reciprocal
    localparam int unsigned EST_SH   = RECIP_SH - PER_W;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;

    // duty = (K2*R^2 - K1*R + K0) / DUTY_DEN, all scaled by 10^4
    localparam logic [NUM_W-1:0] K2       = NUM_W'(86);
    localparam logic [NUM_W-1:0] K1       = NUM_W'(18740);
    localparam logic [NUM_W-1:0] K0       = NUM_W'(1516100);
    localparam logic [DEN_W-1:0] DUTY_DEN = DEN_W'(106300000);

    localparam logic [RECIP_W-1:0] DUTY_RECIP =
        RECIP_W'((64'd1 << RECIP_SH) / 64'(DUTY_DEN));

    localparam logic [RPM_W-1:0] MIN_RPM_RST = RPM_W'(700);
    localparam logic [RPM_W-1:0] MAX_RPM_RST = RPM_W'(1219);
    localparam logic [PER_W-1:0] PERIOD_RST  = PER_W'(328);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RPM    = 2'd0,
        CFG_MAX_RPM    = 2'd1,
        CFG_PWM_PERIOD = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_COMPARE = 1'b0,
        KIND_CHAR    = 1'b1
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic             take_digit;
        logic             take_space;
        logic             do_square;
        logic             do_num;
        logic             do_rem;
        logic             do_mul;
        logic             do_est;
        logic             do_fix;
        logic             do_adj;
        logic             load_msg;
        logic [MSG_W-1:0] msg_idx;
        logic             load_cmp;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_space;
        logic tgt_zero;
        logic out_free;
    } t_sts;

    function automatic logic [BYTE_W-1:0] stop_char(input logic [MSG_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h53; // S
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h6F; // o
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h70; // p
            3'd5:    c = 8'h65; // e
            3'd6:    c = 8'h64; // d
            default: c = 8'h0A; // newline
        endcase
        return c;
    endfunction

endpackage

>>> sv/rpmcmp_ctrl.sv
// ---------------------------------------------------------------------------
// rpmcmp_ctrl
// Sequencer: byte intake, compare pipeline steps, message beats.
// ---------------------------------------------------------------------------
module rpmcmp_ctrl
    import rpmcmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_NUM,
        S_REM,
        S_MUL,
        S_EST,
        S_FIX,
        S_ADJ,
        S_MSG,
        S_CMP
    } t_state;

    t_state           r_state;
    logic [MSG_W-1:0] r_cnt;

    always_comb begin
        o_cmd            = '0;
        o_cmd.take_digit = (r_state == S_IDLE) && i_valid && !i_sts.is_space;
        o_cmd.take_space = (r_state == S_IDLE) && i_valid && i_sts.is_space;
        o_cmd.do_square  = (r_state == S_SQUARE);
        o_cmd.do_num     = (r_state == S_NUM);
        o_cmd.do_rem     = (r_state == S_REM);
        o_cmd.do_mul     = (r_state == S_MUL);
        o_cmd.do_est     = (r_state == S_EST);
        o_cmd.do_fix     = (r_state == S_FIX);
        o_cmd.do_adj     = (r_state == S_ADJ);
        o_cmd.load_msg   = (r_state == S_MSG) && i_sts.out_free;
        o_cmd.msg_idx    = r_cnt;
        o_cmd.load_cmp   = (r_state == S_CMP) && i_sts.out_free;
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (o_cmd.take_space) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: r_state <= S_NUM;
                S_NUM:    r_state <= S_REM;
                S_REM:    r_state <= S_MUL;
                S_MUL:    r_state <= S_EST;
                S_EST:    r_state <= S_FIX;
                S_FIX:    r_state <= S_ADJ;
                S_ADJ: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.tgt_zero ? S_MSG : S_CMP;
                end
                S_MSG: begin
                    if (i_sts.out_free) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == '1) begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_msg || o_cmd.load_cmp) |-> i_sts.out_free)
        else $error("result loaded while output register still full");

    a_space_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_space |=> (r_state == S_SQUARE))
        else $error("space beat did not start compare sequence");

    a_cmp_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_cmp |=> (r_state == S_IDLE))
        else $error("compare beat did not end the sequence");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.do_adj, o_cmd.load_msg, o_cmd.load_cmp, o_cmd.take_digit,
                  o_cmd.take_space}))
        else $error("conflicting datapath commands");
`endif

endmodule

>>> sv/rpmcmp_dp.sv
// ---------------------------------------------------------------------------
// rpmcmp_dp
// Datapath: config registers, digit accumulator, clamp, duty polynomial,
// reciprocal divide by the duty denominator, output register.
// ---------------------------------------------------------------------------
module rpmcmp_dp
    import rpmcmp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PER_W-1:0]     i_cfg_data,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_kind,
    output logic [PER_W-1:0]     o_pwm_compare,
    output logic [RPM_W-1:0]     o_target_rpm,
    output logic [BYTE_W-1:0]    o_tx_char,
    output logic                 o_last
);

    logic [RPM_W-1:0]  r_min_rpm;
    logic [RPM_W-1:0]  r_max_rpm;
    logic [PER_W-1:0]  r_period;
    logic [ACC_W-1:0]  r_acc;
    logic [RPM_W-1:0]  r_tgt;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_lin;
    logic [NUM_W-1:0]  r_num;
    logic              r_neg;
    logic [DEN_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_qd;
    logic [PER_W-1:0]  r_quo;

    logic              r_out_valid;
    logic              r_kind;
    logic [PER_W-1:0]  r_cmp;
    logic [RPM_W-1:0]  r_tgt_out;
    logic [BYTE_W-1:0] r_char;
    logic              r_last;

    logic [ACC_W-1:0]  n_acc;
    logic signed [ACC_W:0] w_acc_s;
    logic signed [ACC_W:0] w_clamp;
    logic [RPM_W-1:0]  n_tgt;
    logic [NUM_W-1:0]  n_num;
    logic [PROD_W-1:0] n_prod;
    logic [EST_W-1:0]  w_est;
    logic [PROD_W-1:0] w_left;
    logic              w_more;
    logic [PER_W-1:0]  w_cmp_val;
    logic              w_taken;

    // acc*10 + byte - '0', wrapping at 16 bits
    assign n_acc = r_acc * ACC_W'(10) + {{(ACC_W-BYTE_W){1'b0}}, i_rx_byte}
                   - {{(ACC_W-BYTE_W){1'b0}}, CHAR_ZERO};

    // clamp high to max first, then low to zero
    always_comb begin
        w_acc_s = {r_acc[ACC_W-1], r_acc};
        w_clamp = w_acc_s;
        if (w_clamp > $signed({2'b00, r_max_rpm})) begin
            w_clamp = $signed({2'b00, r_max_rpm});
        end
        if (w_clamp < $signed({2'b00, r_min_rpm})) begin
            w_clamp = '0;
        end
        n_tgt = w_clamp[RPM_W-1:0];
    end

    assign n_num  = K2 * NUM_W'(r_sq) - NUM_W'(r_lin) + K0;
    assign n_prod = PROD_W'(r_period) * PROD_W'(r_rem);

    // x / DUTY_DEN estimated as ((x >> 16) * DUTY_RECIP) >> 32, never high
    // and at most one low; the remainder check adds the missing one
    assign w_est  = EST_W'(r_prod[PROD_W-1:PER_W]) * EST_W'(DUTY_RECIP);
    assign w_left = r_prod - r_qd;
    assign w_more = (w_left >= PROD_W'(DUTY_DEN));

    always_comb begin
        if (r_tgt == '0) begin
            w_cmp_val = r_period;
        end else if (r_neg) begin
            w_cmp_val = '0;
        end else begin
            w_cmp_val = r_quo;
        end
    end

    assign w_taken = r_out_valid && !i_out_stall;

    assign o_sts.is_space = (i_rx_byte == CHAR_SPACE);
    assign o_sts.tgt_zero = (r_tgt == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rpm <= MIN_RPM_RST;
            r_max_rpm <= MAX_RPM_RST;
            r_period  <= PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_RPM:    r_min_rpm <= i_cfg_data[RPM_W-1:0];
                CFG_MAX_RPM:    r_max_rpm <= i_cfg_data[RPM_W-1:0];
                CFG_PWM_PERIOD: r_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_tgt <= '0;
        end else if (i_cmd.take_digit) begin
            r_acc <= n_acc;
        end else if (i_cmd.take_space) begin
            r_acc <= '0;
            r_tgt <= n_tgt;
        end
    end

    // polynomial and divider registers carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_square) begin
            r_sq  <= SQ_W'(r_tgt) * SQ_W'(r_tgt);
            r_lin <= SQ_W'(r_tgt) * SQ_W'(18740);
        end
        if (i_cmd.do_num) begin
            r_num <= n_num;
        end
        if (i_cmd.do_rem) begin
            r_neg <= (r_num > NUM_W'(DUTY_DEN));
            r_rem <= DUTY_DEN - r_num[DEN_W-1:0];
        end
        if (i_cmd.do_mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.do_est) begin
            r_quo <= w_est[EST_SH +: PER_W];
        end else if (i_cmd.do_adj) begin
            r_quo <= r_quo + PER_W'(w_more);
        end
        if (i_cmd.do_fix) begin
            r_qd <= PROD_W'(r_quo) * PROD_W'(DUTY_DEN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_msg || i_cmd.load_cmp) begin
            r_out_valid <= 1'b1;
        end else if (w_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_msg) begin
            r_kind    <= KIND_CHAR;
            r_cmp     <= '0;
            r_tgt_out <= '0;
            r_char    <= stop_char(i_cmd.msg_idx);
            r_last    <= 1'b0;
        end else if (i_cmd.load_cmp) begin
            r_kind    <= KIND_COMPARE;
            r_cmp     <= w_cmp_val;
            r_tgt_out <= r_tgt;
            r_char    <= '0;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_pwm_compare = r_cmp;
    assign o_target_rpm  = r_tgt_out;
    assign o_tx_char     = r_char;
    assign o_last        = r_last;

endmodule

>>> sv/rpm_command_to_pwm_compare.sv
// ---------------------------------------------------------------------------
// rpm_command_to_pwm_compare
// Serial RPM command decoder producing a PWM compare count per space byte.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  input    | i_valid / o_stall         | i_rx_byte
//  output   | o_valid / i_stall         | o_kind o_pwm_compare o_target_rpm
//           |                           | o_tx_char o_last
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
//  Digit beats never hold off input. A space beat holds off input through
//  square, polynomial, remainder, period product, reciprocal estimate,
//  estimate times denominator, one-step correction, then the compare beat.
//  A zero target puts the 8 message beats before the compare beat.
//  Output stall only stretches the result beats; a result waits in the
//  output register. Synchronous active-low reset; no clearing pass.
// ---------------------------------------------------------------------------
module rpm_command_to_pwm_compare
    import rpmcmp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_kind,
    output logic [PER_W-1:0]     o_pwm_compare,
    output logic [RPM_W-1:0]     o_target_rpm,
    output logic [BYTE_W-1:0]    o_tx_char,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PER_W-1:0]     i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    assign o_stall     = w_busy;
    assign o_cfg_ready = 1'b1;

    rpmcmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    rpmcmp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_rx_byte),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_kind        (o_kind),
        .o_pwm_compare (o_pwm_compare),
        .o_target_rpm  (o_target_rpm),
        .o_tx_char     (o_tx_char),
        .o_last        (o_last)
    );

endmodule

>>> bench/tb_rpm_command_to_pwm_compare.sv
// ---------------------------------------------------------------------------
// tb_rpm_command_to_pwm_compare
// Self-checking bench for the serial RPM command to PWM compare decoder.
// A short table of directed bytes is followed by random commands, most of
// them well-formed digit strings and some noise, under six register settings.
// Every result beat is checked against the predictor or a directed table row.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_rpm_command_to_pwm_compare
    import rpmcmp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 40;     // longer than a space sequence without output stall
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [63:0]       STOP_TEXT  = "Stopped\n";

    // duty = (86 R^2 - 18740 R + 1516100) / 106300000
    localparam longint SQ_COEF     = 86;
    localparam longint LIN_COEF    = 18740;
    localparam longint OFFSET_COEF = 1516100;
    localparam longint DUTY_SCALE  = 106300000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        t_kind             kind;
        logic [PER_W-1:0]  cmp;
        logic [RPM_W-1:0]  tgt;
        logic [BYTE_W-1:0] ch;
        logic              is_last;
    } t_cmd_result;

    // typed rows carry the compare beat of a space, read straight off the spec
    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              typed;
        logic              stop;
        logic [PER_W-1:0]  cmp;
        logic [RPM_W-1:0]  tgt;
    } t_cmd_row;

    localparam t_cmd_row DIRECTED_ROWS [0:23] = '{
        '{" ",   1'b1, 1'b1, 16'd328, 15'd0},      // empty command after reset
        '{"1",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"2",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"1",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"9",   1'b0, 1'b0, 16'd0,   15'd0},
        '{" ",   1'b1, 1'b0, 16'd0,   15'd1219},   // at max: duty above 1
        '{"6",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"9",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"9",   1'b0, 1'b0, 16'd0,   15'd0},
        '{" ",   1'b1, 1'b1, 16'd328, 15'd0},      // just under min
        '{"-",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"1",   1'b0, 1'b0, 16'd0,   15'd0},
        '{" ",   1'b1, 1'b1, 16'd328, 15'd0},      // negative accumulator
        '{8'hFF, 1'b0, 1'b0, 16'd0,   15'd0},
        '{8'h00, 1'b0, 1'b0, 16'd0,   15'd0},
        '{" ",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"7",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"0",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"0",   1'b0, 1'b0, 16'd0,   15'd0},
        '{" ",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"9",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"0",   1'b0, 1'b0, 16'd0,   15'd0},
        '{"0",   1'b0, 1'b0, 16'd0,   15'd0},
        '{" ",   1'b0, 1'b0, 16'd0,   15'd0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_kind;
    logic [PER_W-1:0]     o_pwm_compare;
    logic [RPM_W-1:0]     o_target_rpm;
    logic [BYTE_W-1:0]    o_tx_char;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PER_W-1:0]     i_cfg_data;

    // predictor state and register copy
    logic [ACC_W-1:0] acc_q;
    logic [RPM_W-1:0] speed_q;
    logic [RPM_W-1:0] min_q;
    logic [RPM_W-1:0] max_q;
    logic [PER_W-1:0] period_q;

    t_cmd_result expected_q [$];

    bit gaps_on  = 1'b1;
    bit hold_req = 1'b0;
    int errors       = 0;
    int bytes_sent   = 0;
    int spaces       = 0;
    int stops        = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    rpm_command_to_pwm_compare i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_pwm_compare (o_pwm_compare),
        .o_target_rpm  (o_target_rpm),
        .o_tx_char     (o_tx_char),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [PER_W-1:0] compare_count(input logic [RPM_W-1:0] r,
                                                       input logic [PER_W-1:0] per);
        longint rl;
        longint num;
        longint rem;
        rl = longint'(r);
        if (r == '0) return per;
        num = SQ_COEF * rl * rl - LIN_COEF * rl + OFFSET_COEF;
        rem = DUTY_SCALE - num;
        if (rem < 0) return '0;
        return PER_W'((longint'(per) * rem) / DUTY_SCALE);
    endfunction

    task automatic queue_results(input logic stop, input logic [PER_W-1:0] cmp,
                                 input logic [RPM_W-1:0] tgt);
        t_cmd_result res;
        int i;
        if (stop) begin
            for (i = 0; i < 8; i++) begin
                res      = '0;
                res.kind = KIND_CHAR;
                res.ch   = STOP_TEXT[63-8*i -: 8];
                expected_q.push_back(res);
            end
        end
        res         = '0;
        res.kind    = KIND_COMPARE;
        res.cmp     = cmp;
        res.tgt     = tgt;
        res.is_last = 1'b1;
        expected_q.push_back(res);
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input bit queue_it);
        int acc_s;
        logic [RPM_W-1:0] tgt;
        if (b != SPACE_CHAR) begin
            acc_q = acc_q * 16'd10 + {8'd0, b} - {8'd0, ZERO_CHAR};
        end else begin
            // clamp to max first, then anything under min stops the motor
            acc_s = int'($signed(acc_q));
            if (acc_s > int'(max_q)) acc_s = int'(max_q);
            if (acc_s < int'(min_q)) acc_s = 0;
            tgt     = acc_s[RPM_W-1:0];
            speed_q = tgt;
            spaces++;
            if (tgt == '0) stops++;
            if (queue_it) queue_results(tgt == '0, compare_count(tgt, period_q), tgt);
            acc_q = '0;
        end
    endtask

    // called at a clock edge; returns at the edge where the beat was taken
    // or after the gap that follows it
    task automatic offer_row(input t_cmd_row row);
        int pick;
        int gap;
        i_valid   <= 1'b1;
        i_rx_byte <= row.b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        bytes_sent++;
        if (row.typed) begin
            predict_byte(row.b, 1'b0);
            queue_results(row.stop, row.cmp, row.tgt);
        end else begin
            predict_byte(row.b, 1'b1);
        end
        gap  = 0;
        pick = $urandom_range(99);
        if (gaps_on && pick >= 90)      gap = $urandom_range(40, 10);
        else if (gaps_on && pick >= 55) gap = $urandom_range(3, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic offer_number();
        logic [BYTE_W-1:0] seq [$];
        t_cmd_row row;
        string digits;
        int unsigned mode;
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        int i;
        mode = $urandom_range(99);
        lo   = (min_q > 50) ? min_q - 50 : 0;
        hi   = max_q + 50;
        if (mode < 60) v = $urandom_range(hi, lo);
        else           v = $urandom_range(99999);
        if (mode < 85) begin
            digits = $sformatf("%0d", v);
            for (i = 0; i < digits.len(); i++) seq.push_back(digits[i]);
        end
        // noise byte dropped into an otherwise good number
        if (mode >= 75 && mode < 85)
            seq.insert($urandom_range(seq.size()), 8'($urandom_range(255)));
        if (mode >= 85) begin
            repeat ($urandom_range(6, 1)) seq.push_back(8'($urandom_range(255)));
        end
        seq.push_back(SPACE_CHAR);
        for (i = 0; i < seq.size(); i++) begin
            row   = '0;
            row.b = seq[i];
            offer_row(row);
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) offer_number();
    endtask

    // stop offering, wait for every expected beat, then let the block settle
    task automatic park();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PER_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_MIN_RPM:    min_q    = data[RPM_W-1:0];
            CFG_MAX_RPM:    max_q    = data[RPM_W-1:0];
            CFG_PWM_PERIOD: period_q = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_cmd_result exp_r;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: kind %0d compare %0d target %0d char %0d",
                         $time, o_kind, o_pwm_compare, o_target_rpm, o_tx_char);
            end else begin
                exp_r = expected_q.pop_front();
                results_seen++;
                check_field("kind",        16'(exp_r.kind),    16'(o_kind));
                check_field("pwm_compare", exp_r.cmp,          o_pwm_compare);
                check_field("target_rpm",  16'(exp_r.tgt),     16'(o_target_rpm));
                check_field("tx_char",     16'(exp_r.ch),      16'(o_tx_char));
                check_field("last",        16'(exp_r.is_last), 16'(o_last));
            end
        end
    end

    // receiver: random stall runs, one long hold-off on request
    initial begin : result_stall
        int unsigned pick;
        int unsigned len;
        bit val;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                val      = 1'b1;
                len      = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                pick = $urandom_range(99);
                if (pick < 50)      begin val = 1'b0; len = $urandom_range(20, 1); end
                else if (pick < 85) begin val = 1'b1; len = $urandom_range(3, 1);  end
                else if (pick < 95) begin val = 1'b0; len = $urandom_range(80, 20); end
                else                begin val = 1'b1; len = $urandom_range(40, 10); end
            end
            i_stall <= val;
            repeat (len) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t timeout: no beat for %0d cycles, %0d beats outstanding",
                 $time, IDLE_LIMIT, expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int k;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        acc_q       = '0;
        speed_q     = '0;
        min_q       = 15'd700;
        max_q       = 15'd1219;
        period_q    = 16'd328;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < $size(DIRECTED_ROWS); k++) offer_row(DIRECTED_ROWS[k]);

        // reset settings, with the long output hold-off
        hold_req = 1'b1;
        run_random(60);
        park();

        // full range, bit 15 of the rpm data must be dropped; no sender gaps
        cfg_write(CFG_MIN_RPM, 16'h0000);
        cfg_write(CFG_MAX_RPM, 16'hFFFF);
        cfg_write(CFG_PWM_PERIOD, 16'hFFFF);
        gaps_on = 1'b0;
        run_random(50);
        park();
        gaps_on = 1'b1;

        // min above max: every command stops
        cfg_write(CFG_MIN_RPM, 16'h7FFF);
        cfg_write(CFG_MAX_RPM, 16'h8000);
        cfg_write(CFG_PWM_PERIOD, 16'd1);
        run_random(40);
        park();

        // zero period, low speeds; sender pauses midway until all beats are in
        cfg_write(CFG_MIN_RPM, 16'd0);
        cfg_write(CFG_MAX_RPM, 16'd100);
        cfg_write(CFG_PWM_PERIOD, 16'd0);
        run_random(20);
        park();
        run_random(20);
        park();

        // random settings, plus a write to the unused index
        cfg_write(CFG_MIN_RPM, 16'($urandom_range(1500)));
        cfg_write(CFG_MAX_RPM, 16'($urandom_range(2000, 500)));
        cfg_write(CFG_PWM_PERIOD, 16'($urandom_range(65535, 1)));
        cfg_write(CFG_IDX_SPARE, 16'($urandom_range(65535)));
        run_random(50);
        park();

        cfg_write(CFG_MIN_RPM, 16'd700);
        cfg_write(CFG_MAX_RPM, 16'd1219);
        cfg_write(CFG_PWM_PERIOD, 16'd328);
        run_random(60);
        park();

        $display("Sent %0d bytes: %0d commands, %0d of them stops; checked %0d result beats",
                 bytes_sent, spaces, stops, results_seen);
        $display("%0d register writes: reset values, full range, min above max, zero period",
                 cfg_writes);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
